/* hdl/bts_pkg.sv */
package bts_pkg;

  // default store geometry
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // queue depths and their count widths
  localparam int MID_DEPTH = 8;
  localparam int OUT_DEPTH = 8;
  localparam int MID_CW    = $clog2(MID_DEPTH + 1);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  // remainder pipeline: 16-bit magnitude, four bits per stage
  localparam int MOD_BITS   = 4;
  localparam int MOD_STAGES = 4;

  // commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // register indexes
  localparam logic [1:0] REG_WRAP   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // item inside the front pipeline
  typedef struct packed {
    logic               cmd;
    logic               wen;
    logic [5:0]         col;
    logic [5:0]         row;
    logic [63:0]        texel;
    logic [7:0]         fx;
    logic [7:0]         fy;
    logic signed [15:0] ix;
    logic signed [15:0] iy;
    logic [15:0]        magx;
    logic [15:0]        magy;
    logic [6:0]         w;
    logic [6:0]         h;
    logic               wrap;
    logic [6:0]         rx;
    logic [6:0]         ry;
  } fr_t;

  // classified item between front and back
  typedef struct packed {
    logic        cmd;
    logic        wen;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [63:0] texel;
    logic [6:0]  x0;
    logic [6:0]  x1;
    logic [6:0]  y0;
    logic [6:0]  y1;
    logic [7:0]  fx;
    logic [7:0]  fy;
  } bk_t;

  // a few steps of restoring remainder
  function automatic logic [6:0] mod_step(input logic [6:0] r,
                                          input logic [MOD_BITS-1:0] bits,
                                          input logic [6:0] s);
    logic [7:0] t;
    logic [6:0] acc;
    acc = r;
    for (int i = MOD_BITS - 1; i >= 0; i--) begin
      t = {acc, bits[i]};
      if (t >= {1'b0, s}) t = t - {1'b0, s};
      acc = t[6:0];
    end
    return acc;
  endfunction

  // (b - a) * f, signed
  function automatic logic signed [25:0] lerp_mul(input logic [15:0] a,
                                                  input logic [15:0] b,
                                                  input logic [7:0] f);
    logic signed [16:0] d;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    return d * $signed({1'b0, f});
  endfunction

  // a + product / 256, truncated toward zero
  function automatic logic [15:0] lerp_add(input logic [15:0] a,
                                           input logic signed [25:0] p);
    logic signed [25:0] adj;
    logic signed [17:0] sum;
    adj = p + (p < 0 ? 26'sd255 : 26'sd0);
    sum = $signed({2'b00, a}) + $signed(adj[25:8]);
    return sum[15:0];
  endfunction

endpackage

/* hdl/bts_fifo.sv */
module bts_fifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             din,
  input  logic                         pop,
  output logic [WIDTH-1:0]             dout,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   cnt
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    cnt_r;

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  assign dout  = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign cnt   = cnt_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r < CW'(DEPTH)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("queue underflow");
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1) else $error("level slip");

endmodule

/* hdl/bts_front.sv */
module bts_front #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_command,
  input  logic [5:0]                  in_col,
  input  logic [5:0]                  in_row,
  input  logic [63:0]                 in_texel,
  input  logic signed [23:0]          in_cx,
  input  logic signed [23:0]          in_cy,
  input  logic                        wrap,
  input  logic [6:0]                  width,
  input  logic [6:0]                  height,
  input  logic [bts_pkg::MID_CW-1:0]  mid_cnt,
  output logic                        q_push,
  output bts_pkg::bk_t                q_item
);
  import bts_pkg::*;

  localparam int NST = MOD_STAGES + 1;
  localparam int CW  = $clog2(NST + 1);

  fr_t            st_r [NST];
  logic [NST-1:0] vld_r;
  logic [CW-1:0]  infl_r;
  logic           acc;
  fr_t            s0;
  fr_t            last;
  logic [13:0]    nx;
  logic [13:0]    ny;

  function automatic logic [6:0] eff_size(input logic [6:0] r, input int mx);
    if (r == 7'd0) return 7'd1;
    if (int'(r) > mx) return 7'(mx);
    return r;
  endfunction

  // both neighbours of one axis, packed {first, second}
  function automatic logic [13:0] nbr(input logic signed [15:0] ip,
                                      input logic [6:0] r,
                                      input logic [6:0] s,
                                      input logic wr);
    logic [6:0]         m;
    logic [6:0]         m1;
    logic [6:0]         c0;
    logic [6:0]         c1;
    logic signed [16:0] ip0;
    logic signed [16:0] ip1;
    logic signed [16:0] smax;
    m    = (ip[15] && r != 7'd0) ? s - r : r;
    m1   = (m + 7'd1 == s) ? 7'd0 : m + 7'd1;
    ip0  = {ip[15], ip};
    ip1  = ip0 + 17'sd1;
    smax = $signed({10'b0, s}) - 17'sd1;
    c0   = ip0 < 0 ? 7'd0 : (ip0 > smax ? s - 7'd1 : ip0[6:0]);
    c1   = ip1 < 0 ? 7'd0 : (ip1 > smax ? s - 7'd1 : ip1[6:0]);
    return wr ? {m, m1} : {c0, c1};
  endfunction

  // room check against queue level plus items still in flight
  assign in_full = (32'(mid_cnt) + 32'(infl_r)) >= MID_DEPTH;
  assign acc     = in_push && !in_full;

  // classify and split the coordinates
  always_comb begin
    s0       = '0;
    s0.cmd   = in_command;
    s0.wen   = (32'(in_col) < MAX_WIDTH) && (32'(in_row) < MAX_HEIGHT);
    s0.col   = in_col;
    s0.row   = in_row;
    s0.texel = in_texel;
    s0.fx    = in_cx[7:0];
    s0.fy    = in_cy[7:0];
    s0.ix    = in_cx[23:8];
    s0.iy    = in_cy[23:8];
    s0.magx  = in_cx[23] ? 16'(-in_cx[23:8]) : in_cx[23:8];
    s0.magy  = in_cy[23] ? 16'(-in_cy[23:8]) : in_cy[23:8];
    s0.w     = eff_size(width, MAX_WIDTH);
    s0.h     = eff_size(height, MAX_HEIGHT);
    s0.wrap  = wrap;
    s0.rx    = 7'd0;
    s0.ry    = 7'd0;
  end

  always_ff @(posedge clk) begin
    st_r[0] <= s0;
  end

  // remainder stages, most significant nibble first
  for (genvar k = 1; k < NST; k++) begin : g_mod
    fr_t st_nxt;

    always_comb begin
      st_nxt    = st_r[k-1];
      st_nxt.rx = mod_step(st_r[k-1].rx,
                           st_r[k-1].magx[MOD_BITS*(NST-1-k) +: MOD_BITS],
                           st_r[k-1].w);
      st_nxt.ry = mod_step(st_r[k-1].ry,
                           st_r[k-1].magy[MOD_BITS*(NST-1-k) +: MOD_BITS],
                           st_r[k-1].h);
    end

    always_ff @(posedge clk) begin
      st_r[k] <= st_nxt;
    end
  end

  // valid bits and in-flight count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      infl_r <= '0;
    end else begin
      vld_r  <= {vld_r[NST-2:0], acc};
      infl_r <= infl_r + CW'(acc) - CW'(q_push);
    end
  end

  // neighbour selection at the tail
  assign last = st_r[NST-1];
  assign nx   = nbr(last.ix, last.rx, last.w, last.wrap);
  assign ny   = nbr(last.iy, last.ry, last.h, last.wrap);

  assign q_push       = vld_r[NST-1];
  assign q_item.cmd   = last.cmd;
  assign q_item.wen   = last.wen;
  assign q_item.col   = last.col;
  assign q_item.row   = last.row;
  assign q_item.texel = last.texel;
  assign q_item.x0    = nx[13:7];
  assign q_item.x1    = nx[6:0];
  assign q_item.y0    = ny[13:7];
  assign q_item.y1    = ny[6:0];
  assign q_item.fx    = last.fx;
  assign q_item.fy    = last.fy;

endmodule

/* hdl/bts_back.sv */
module bts_back #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  bts_pkg::bk_t                q_item,
  output logic                        q_pop,
  input  logic [bts_pkg::OUT_CW-1:0]  out_cnt,
  output logic                        o_push,
  output logic [63:0]                 o_px
);
  import bts_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = 3;

  logic                    rd_en;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [AW-1:0]           raddr [4];
  logic [63:0]             rd_r  [4];
  logic [CW-1:0]           infl_r;
  logic                    v1_r, v2_r, v3_r, v4_r;
  logic [7:0]              fx1_r, fy1_r, fy2_r, fy3_r;
  logic [15:0]             a2_r [8];
  logic signed [25:0]      p2_r [8];
  logic [15:0]             t3_r [8];
  logic [15:0]             a4_r [4];
  logic signed [25:0]      p4_r [4];

  // issue: writes always, samples only with room downstream
  assign q_pop = !q_empty && (q_item.cmd == CMD_WRITE ||
                 (32'(out_cnt) + 32'(infl_r)) < OUT_DEPTH);
  assign rd_en = q_pop && q_item.cmd == CMD_SAMPLE;
  assign we    = q_pop && q_item.cmd == CMD_WRITE && q_item.wen;

  assign waddr    = AW'(q_item.row) * AW'(MAX_WIDTH) + AW'(q_item.col);
  assign raddr[0] = AW'(q_item.y0) * AW'(MAX_WIDTH) + AW'(q_item.x0);
  assign raddr[1] = AW'(q_item.y0) * AW'(MAX_WIDTH) + AW'(q_item.x1);
  assign raddr[2] = AW'(q_item.y1) * AW'(MAX_WIDTH) + AW'(q_item.x0);
  assign raddr[3] = AW'(q_item.y1) * AW'(MAX_WIDTH) + AW'(q_item.x1);

  // four copies of the texel store, one per corner
  for (genvar c = 0; c < 4; c++) begin : g_store
    logic [63:0] mem [DEPTH];
    always_ff @(posedge clk) begin
      if (we)    mem[waddr] <= q_item.texel;
      if (rd_en) rd_r[c]    <= mem[raddr[c]];
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      infl_r <= '0;
    end else begin
      v1_r   <= rd_en;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      v4_r   <= v3_r;
      infl_r <= infl_r + CW'(rd_en) - CW'(v4_r);
    end
  end

  // horizontal products, then sums, then vertical products
  always_ff @(posedge clk) begin
    fx1_r <= q_item.fx;
    fy1_r <= q_item.fy;
    fy2_r <= fy1_r;
    fy3_r <= fy2_r;
    for (int k = 0; k < 4; k++) begin
      a2_r[2*k]   <= rd_r[0][16*k +: 16];
      p2_r[2*k]   <= lerp_mul(rd_r[0][16*k +: 16], rd_r[1][16*k +: 16], fx1_r);
      a2_r[2*k+1] <= rd_r[2][16*k +: 16];
      p2_r[2*k+1] <= lerp_mul(rd_r[2][16*k +: 16], rd_r[3][16*k +: 16], fx1_r);
    end
    for (int j = 0; j < 8; j++) begin
      t3_r[j] <= lerp_add(a2_r[j], p2_r[j]);
    end
    for (int k = 0; k < 4; k++) begin
      a4_r[k] <= t3_r[2*k];
      p4_r[k] <= lerp_mul(t3_r[2*k], t3_r[2*k+1], fy3_r);
    end
  end

  // final vertical sum
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      o_px[16*k +: 16] = lerp_add(a4_r[k], p4_r[k]);
    end
  end

  assign o_push = v4_r;

endmodule

/* hdl/bilinear_texel_sampler_core.sv */
// A write reaches the texel store through the front pipeline and the middle
// queue; a sample result then passes the back pipeline to the output queue.
// Throughput: one transaction per cycle while in_full is low, set by the
// 5-stage remainder pipeline and the 4-stage read and interpolate pipeline.
// Reset (rst_n, synchronous, active low) clears queues, pipeline valids and
// registers (clamp, 64 x 64); the texel store is not cleared.
module bilinear_texel_sampler_core #(
  parameter int MAX_WIDTH  = bts_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bts_pkg::MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_command,
  input  logic [5:0]         in_texel_col,
  input  logic [5:0]         in_texel_row,
  input  logic [15:0]        in_red,
  input  logic [15:0]        in_green,
  input  logic [15:0]        in_blue,
  input  logic [15:0]        in_alpha,
  input  logic signed [23:0] in_coord_x,
  input  logic signed [23:0] in_coord_y,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [15:0]        out_red,
  output logic [15:0]        out_green,
  output logic [15:0]        out_blue,
  output logic [15:0]        out_alpha
);
  import bts_pkg::*;

  logic              wrap_r;
  logic [6:0]        width_r;
  logic [6:0]        height_r;
  logic              q_push;
  bk_t               q_in;
  logic [$bits(bk_t)-1:0] q_dout;
  logic              q_pop;
  logic              q_empty;
  logic [MID_CW-1:0] q_cnt;
  logic              o_push;
  logic [63:0]       o_px;
  logic [63:0]       o_dout;
  logic [OUT_CW-1:0] o_cnt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r   <= 1'b0;
      width_r  <= 7'd64;
      height_r <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WRAP:   wrap_r   <= cfg_data[0];
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  bts_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_command (in_command),
    .in_col     (in_texel_col),
    .in_row     (in_texel_row),
    .in_texel   ({in_alpha, in_blue, in_green, in_red}),
    .in_cx      (in_coord_x),
    .in_cy      (in_coord_y),
    .wrap       (wrap_r),
    .width      (width_r),
    .height     (height_r),
    .mid_cnt    (q_cnt),
    .q_push     (q_push),
    .q_item     (q_in)
  );

  // decoupling queue between front and back
  bts_fifo #(.WIDTH($bits(bk_t)), .DEPTH(MID_DEPTH)) u_mid (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .cnt   (q_cnt)
  );

  bts_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_item  (bk_t'(q_dout)),
    .q_pop   (q_pop),
    .out_cnt (o_cnt),
    .o_push  (o_push),
    .o_px    (o_px)
  );

  // result queue
  bts_fifo #(.WIDTH(64), .DEPTH(OUT_DEPTH)) u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .din   (o_px),
    .pop   (out_pop && !out_empty),
    .dout  (o_dout),
    .empty (out_empty),
    .cnt   (o_cnt)
  );

  assign out_red   = o_dout[15:0];
  assign out_green = o_dout[31:16];
  assign out_blue  = o_dout[47:32];
  assign out_alpha = o_dout[63:48];

endmodule
